>>> hw/rtl/ekvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekvt_pkg: shared types and constants
// sizes, operation codes, request/response payloads and cell link structs
// ----------------------------------------------------------------------------
package ekvt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int TIME_W      = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OUT_CNT_W   = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_INSERT,
        ACT_PULL
    } t_cell_act;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } t_state;

    typedef struct packed {
        t_op               operation;
        logic [KEY_W-1:0]  entry_key;
        logic [VAL_W-1:0]  entry_value;
        logic [TIME_W-1:0] expiry_stamp;
        logic [TIME_W-1:0] now_time;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic [VAL_W-1:0]     read_value;
        logic                 dropped;
        logic [OUT_CNT_W-1:0] entry_count;
    } t_rsp;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    typedef struct packed {
        t_cell_act         act;
        t_entry            ins;
        logic [TIME_W-1:0] now;
    } t_cell_cmd;

    typedef struct packed {
        t_entry           entry;
        logic             gt;
        logic             found;
        logic [VAL_W-1:0] value;
    } t_cell_link;

endpackage

>>> hw/rtl/ekvt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekvt_req_if: request channel
// valid/ready handshake carrying one table operation
// ----------------------------------------------------------------------------
interface ekvt_req_if import ekvt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ekvt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekvt_rsp_if: response channel
// valid/ready handshake carrying one operation result
// ----------------------------------------------------------------------------
interface ekvt_rsp_if import ekvt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/ekvt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekvt_cell: one table slot
// holds one entry, compares it against the broadcast command and passes
// entry, insert position and lookup result on to its neighbor
// ----------------------------------------------------------------------------
module ekvt_cell import ekvt_pkg::*; (
    input  logic       i_clk,
    input  t_cell_cmd  i_cmd,
    input  logic       i_occ,
    input  t_cell_link i_prev,
    input  t_entry     i_next_entry,
    output t_cell_link o_link,
    output logic       o_stale
);

    t_entry r_entry;
    t_entry n_entry;
    logic   gt;
    logic   match;

    assign gt    = !i_occ || (r_entry.expiry > i_cmd.ins.expiry);
    assign match = i_occ && !(i_cmd.now > r_entry.expiry) && (r_entry.key == i_cmd.ins.key);

    assign o_stale      = i_occ && (r_entry.expiry < i_cmd.now);
    assign o_link.entry = r_entry;
    assign o_link.gt    = gt;
    assign o_link.found = i_prev.found || match;
    assign o_link.value = i_prev.found ? i_prev.value : (match ? r_entry.value : '0);

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.act)
            ACT_INSERT: begin
                if (gt) begin
                    n_entry = i_prev.gt ? i_prev.entry : i_cmd.ins;
                end
            end
            ACT_PULL: begin
                n_entry = i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> hw/rtl/expiring_key_value_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// expiring_key_value_table_core: expiring key/value table
// Entries of key, value and expiry are held in a row of cells, sorted by
// expiry. Requests arrive on i_req (insert, lookup, sweep) and each gives
// exactly one result on o_rsp; an item transfers when valid and ready are
// both high.
// Insert and lookup first register the request; then, once the output
// register is free, all cells compare in parallel, the insert shifts the
// tail down by one cell and the result is loaded. Sweep removes expired
// entries from the head: the row shifts up one cell per cycle while the
// head entry is expired; the result then waits for a free output register.
// One request is in work at a time; i_req.ready is high only while idle.
// The result sits in an output register; a new request is taken while it
// waits, and a finished operation waits until that register is free.
// Reset empties the table (count zero) and drops any pending result.
// ----------------------------------------------------------------------------
module expiring_key_value_table_core import ekvt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ekvt_req_if.sink   i_req,
    ekvt_rsp_if.source o_rsp
);

    t_state           r_state;
    t_state           n_state;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    t_cell_cmd  cmd;
    t_cell_link lnk [TABLE_DEPTH];
    logic       stale [TABLE_DEPTH];
    logic       free;
    logic       full;
    logic       head_stale;
    logic       rsp_load;

    assign free       = !r_out_valid || o_rsp.ready;
    assign full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign head_stale = stale[0];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            t_cell_link prev;
            t_entry     next_entry;
            logic       occ;

            assign occ = (CNT_W'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign prev = '0;
            end else begin : g_body
                assign prev = lnk[gi-1];
            end

            if (gi == TABLE_DEPTH - 1) begin : g_tail
                assign next_entry = '0;
            end else begin : g_inner
                assign next_entry = lnk[gi+1].entry;
            end

            ekvt_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (cmd),
                .i_occ        (occ),
                .i_prev       (prev),
                .i_next_entry (next_entry),
                .o_link       (lnk[gi]),
                .o_stale      (stale[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = (i_req.data.operation == OP_SWEEP) ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                if (!head_stale && free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready    = 1'b0;
        cmd.act        = ACT_HOLD;
        cmd.ins.key    = r_req.entry_key;
        cmd.ins.value  = r_req.entry_value;
        cmd.ins.expiry = r_req.expiry_stamp;
        cmd.now        = r_req.now_time;
        rsp_load       = 1'b0;
        n_count        = r_count;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
            end
            ST_EXEC: begin
                if (free) begin
                    rsp_load = 1'b1;
                    if (r_req.operation == OP_INSERT && !full) begin
                        cmd.act = ACT_INSERT;
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_SWEEP: begin
                if (head_stale) begin
                    cmd.act = ACT_PULL;
                    n_count = r_count - CNT_W'(1);
                end else if (free) begin
                    rsp_load = 1'b1;
                end
            end
            default: begin
                i_req.ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_rsp.hit         = (r_req.operation == OP_LOOKUP) && lnk[TABLE_DEPTH-1].found;
        n_rsp.read_value  = n_rsp.hit ? lnk[TABLE_DEPTH-1].value : '0;
        n_rsp.dropped     = (r_req.operation == OP_INSERT) && full;
        n_rsp.entry_count = OUT_CNT_W'(n_count);
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.data;
        end
        if (rsp_load) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
